### src/hcd_pkg.sv
package hcd_pkg;

	localparam int SIZE_BITS     = 32;
	localparam int SIZE_TEXT_MAX = 32;
	localparam int STC_W         = 6;
	localparam int LINE_W        = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LINE_W-1:0] MAX_LINE_RESET = LINE_W'(16384);

	localparam logic [1:0] REQ_BYTE    = 2'd0;
	localparam logic [1:0] REQ_CLOSE   = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_CLOSE,
		OP_RESTART,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		KIND_BODY = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_TEXT_LONG = 3'd0,
		ERR_NO_DIGITS = 3'd1,
		ERR_NO_CRLF   = 3'd2,
		ERR_CLOSED    = 3'd3,
		ERR_LINE_LONG = 3'd4
	} err_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_ws;
		logic       is_semi;
		logic       is_cr;
		logic       is_lf;
	} item_t;

endpackage

### src/hcd_req_if.sv
interface hcd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] in_byte;

	modport source (output valid, output req_type, output in_byte, input ready);
	modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

### src/hcd_rsp_if.sv
interface hcd_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] body_byte;
	logic [2:0] error_code;

	modport source (output valid, output kind, output body_byte, output error_code, input ready);
	modport sink (input valid, input kind, input body_byte, input error_code, output ready);
endinterface

### src/hcd_cfg_if.sv
interface hcd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/hcd_front.sv
module hcd_front (
	hcd_req_if.sink          req,
	input  logic             full,
	output logic             push,
	output hcd_pkg::item_t   item
);

	logic [7:0] b;

	assign b        = req.in_byte;
	assign req.ready = !full;
	assign push     = req.valid && !full;

	always_comb begin
		item         = '0;
		item.data    = b;
		item.is_semi = (b == hcd_pkg::CH_SEMI);
		item.is_cr   = (b == hcd_pkg::CH_CR);
		item.is_lf   = (b == hcd_pkg::CH_LF);
		item.is_ws   = (b == hcd_pkg::CH_SP) || (b == hcd_pkg::CH_TAB);
		case (req.req_type)
			hcd_pkg::REQ_BYTE:    item.op = hcd_pkg::OP_BYTE;
			hcd_pkg::REQ_CLOSE:   item.op = hcd_pkg::OP_CLOSE;
			hcd_pkg::REQ_RESTART: item.op = hcd_pkg::OP_RESTART;
			default:              item.op = hcd_pkg::OP_NONE;
		endcase
		if (b inside {[8'h30:8'h39]}) begin
			item.is_hex  = 1'b1;
			item.hex_val = 4'(b - 8'h30);
		end else if (b inside {[8'h61:8'h66]}) begin
			item.is_hex  = 1'b1;
			item.hex_val = 4'(b - 8'h57);
		end else if (b inside {[8'h41:8'h46]}) begin
			item.is_hex  = 1'b1;
			item.hex_val = 4'(b - 8'h37);
		end
	end

endmodule

### src/hcd_queue.sv
module hcd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hcd_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output hcd_pkg::item_t pop_item,
	output logic           empty
);

	localparam logic [hcd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
		hcd_pkg::QUEUE_PTR_W'(hcd_pkg::QUEUE_DEPTH - 1);
	localparam logic [hcd_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
		hcd_pkg::QUEUE_CNT_W'(hcd_pkg::QUEUE_DEPTH);

	hcd_pkg::item_t                  mem_q [hcd_pkg::QUEUE_DEPTH];
	logic [hcd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [hcd_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [hcd_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_FULL) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");
`endif

endmodule

### src/hcd_back.sv
module hcd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [hcd_pkg::LINE_W-1:0]  max_line,
	input  logic                        empty,
	input  hcd_pkg::item_t              item,
	output logic                        pop,
	hcd_rsp_if.source                   rsp
);

	typedef enum logic [3:0] {
		PH_SIZE,
		PH_EXT,
		PH_DATA,
		PH_CR,
		PH_LF,
		PH_TRAIL,
		PH_DONE,
		PH_ERR
	} phase_t;

	typedef struct packed {
		phase_t                         ph;
		logic [hcd_pkg::STC_W-1:0]      stc;
		logic [hcd_pkg::SIZE_BITS-1:0]  size;
		logic                           ds;
		logic                           de;
	} line_t;

	localparam logic [hcd_pkg::STC_W-1:0] STC_SAT = '1;
	localparam logic [hcd_pkg::STC_W-1:0] STC_MAX = hcd_pkg::STC_W'(hcd_pkg::SIZE_TEXT_MAX);

	function automatic line_t content(line_t s, logic semi, logic ws, logic hex,
			logic [3:0] hv);
		line_t r;
		r = s;
		if (s.ph == PH_SIZE) begin
			if (semi) begin
				r.ph = PH_EXT;
			end else begin
				if (s.stc != STC_SAT) begin
					r.stc = s.stc + 1'b1;
				end
				if (!s.de && !(!s.ds && ws)) begin
					if (!hex) begin
						r.de = 1'b1;
					end else begin
						r.ds = 1'b1;
						if (s.size[hcd_pkg::SIZE_BITS-1 -: 4] != 4'h0) begin
							r.size = '1;
						end else begin
							r.size = {s.size[hcd_pkg::SIZE_BITS-5:0], hv};
						end
					end
				end
			end
		end
		return r;
	endfunction

	phase_t                         ph_q, ph_d;
	logic [hcd_pkg::SIZE_BITS-1:0]  rem_q, rem_d;
	logic [hcd_pkg::STC_W-1:0]      stc_q, stc_d;
	logic [hcd_pkg::LINE_W-1:0]     lbc_q, lbc_d;
	logic [hcd_pkg::SIZE_BITS-1:0]  size_q, size_d;
	logic                           ds_q, ds_d;
	logic                           de_q, de_d;
	logic                           cr_q, cr_d;
	logic                           out_v_q;
	logic [1:0]                     kind_q;
	logic [7:0]                     body_q;
	logic [2:0]                     code_q;
	logic                           res_v;
	hcd_pkg::kind_t                 res_kind;
	logic [7:0]                     res_body;
	hcd_pkg::err_t                  res_code;
	line_t                          ls;
	logic [hcd_pkg::LINE_W:0]       lbc_inc;

	assign pop            = !empty && (!out_v_q || rsp.ready);
	assign rsp.valid      = out_v_q;
	assign rsp.kind       = kind_q;
	assign rsp.body_byte  = body_q;
	assign rsp.error_code = code_q;
	assign lbc_inc        = {1'b0, lbc_q} + 1'b1;

	always_comb begin
		ph_d     = ph_q;
		rem_d    = rem_q;
		stc_d    = stc_q;
		lbc_d    = lbc_q;
		size_d   = size_q;
		ds_d     = ds_q;
		de_d     = de_q;
		cr_d     = cr_q;
		res_v    = 1'b0;
		res_kind = hcd_pkg::KIND_BODY;
		res_body = '0;
		res_code = hcd_pkg::ERR_TEXT_LONG;
		ls       = '{ph: ph_q, stc: stc_q, size: size_q, ds: ds_q, de: de_q};
		if (pop) begin
			case (item.op)
				hcd_pkg::OP_RESTART: begin
					ph_d   = PH_SIZE;
					rem_d  = '0;
					stc_d  = '0;
					lbc_d  = '0;
					size_d = '0;
					ds_d   = 1'b0;
					de_d   = 1'b0;
					cr_d   = 1'b0;
				end
				hcd_pkg::OP_CLOSE: begin
					if (ph_q != PH_ERR && ph_q != PH_DONE) begin
						ph_d     = PH_ERR;
						res_v    = 1'b1;
						res_kind = hcd_pkg::KIND_ERR;
						res_code = hcd_pkg::ERR_CLOSED;
					end
				end
				hcd_pkg::OP_BYTE: begin
					case (ph_q)
						PH_ERR, PH_DONE: begin
						end
						PH_DATA: begin
							rem_d    = rem_q - 1'b1;
							if (rem_q == hcd_pkg::SIZE_BITS'(1)) begin
								ph_d = PH_CR;
							end
							res_v    = 1'b1;
							res_kind = hcd_pkg::KIND_BODY;
							res_body = item.data;
						end
						PH_CR: begin
							if (!item.is_cr) begin
								ph_d     = PH_ERR;
								res_v    = 1'b1;
								res_kind = hcd_pkg::KIND_ERR;
								res_code = hcd_pkg::ERR_NO_CRLF;
							end else begin
								ph_d = PH_LF;
							end
						end
						PH_LF: begin
							if (!item.is_lf) begin
								ph_d     = PH_ERR;
								res_v    = 1'b1;
								res_kind = hcd_pkg::KIND_ERR;
								res_code = hcd_pkg::ERR_NO_CRLF;
							end else begin
								ph_d   = PH_SIZE;
								stc_d  = '0;
								lbc_d  = '0;
								size_d = '0;
								ds_d   = 1'b0;
								de_d   = 1'b0;
								cr_d   = 1'b0;
							end
						end
						default: begin
							if (cr_q && item.is_lf) begin
								stc_d  = '0;
								lbc_d  = '0;
								size_d = '0;
								ds_d   = 1'b0;
								de_d   = 1'b0;
								cr_d   = 1'b0;
								if (ph_q == PH_TRAIL) begin
									if (lbc_q == hcd_pkg::LINE_W'(1)) begin
										ph_d     = PH_DONE;
										res_v    = 1'b1;
										res_kind = hcd_pkg::KIND_DONE;
									end
								end else if (stc_q >= STC_MAX) begin
									ph_d     = PH_ERR;
									res_v    = 1'b1;
									res_kind = hcd_pkg::KIND_ERR;
									res_code = hcd_pkg::ERR_TEXT_LONG;
								end else if (!ds_q) begin
									ph_d     = PH_ERR;
									res_v    = 1'b1;
									res_kind = hcd_pkg::KIND_ERR;
									res_code = hcd_pkg::ERR_NO_DIGITS;
								end else begin
									rem_d = size_q;
									ph_d  = (size_q == '0) ? PH_TRAIL : PH_DATA;
								end
							end else begin
								if (cr_q) begin
									ls = content(ls, 1'b0, 1'b0, 1'b0, 4'h0);
								end
								if (!item.is_cr) begin
									ls = content(ls, item.is_semi, item.is_ws, item.is_hex,
										item.hex_val);
								end
								cr_d   = item.is_cr;
								ph_d   = ls.ph;
								stc_d  = ls.stc;
								size_d = ls.size;
								ds_d   = ls.ds;
								de_d   = ls.de;
								lbc_d  = lbc_inc[hcd_pkg::LINE_W-1:0];
								if (lbc_inc >= {1'b0, max_line}) begin
									ph_d     = PH_ERR;
									res_v    = 1'b1;
									res_kind = hcd_pkg::KIND_ERR;
									res_code = hcd_pkg::ERR_LINE_LONG;
								end
							end
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_SIZE;
			rem_q   <= '0;
			stc_q   <= '0;
			lbc_q   <= '0;
			size_q  <= '0;
			ds_q    <= 1'b0;
			de_q    <= 1'b0;
			cr_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			ph_q   <= ph_d;
			rem_q  <= rem_d;
			stc_q  <= stc_d;
			lbc_q  <= lbc_d;
			size_q <= size_d;
			ds_q   <= ds_d;
			de_q   <= de_d;
			cr_q   <= cr_d;
			if (res_v) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			kind_q <= res_kind;
			body_q <= res_body;
			code_q <= res_code;
		end
	end

`ifndef SYNTHESIS
	a_err_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v && res_kind == hcd_pkg::KIND_ERR) |=> ph_q == PH_ERR)
		else $error("error raised without entering error phase");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_ERR && !(pop && item.op == hcd_pkg::OP_RESTART)) |=> ph_q == PH_ERR)
		else $error("left error phase without restart");
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_DATA |-> rem_q != '0)
		else $error("data phase with nothing left");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !rsp.ready) |-> !res_v)
		else $error("result register overwritten while stalled");
`endif

endmodule

### src/http_chunked_body_decoder_core.sv
// HTTP/1.1 chunked body decoder.
// req: one transaction per stream event; req_type 0 carries in_byte, 1 reports
//   the connection closed, 2 restarts for a new message.
// rsp: zero or one transaction per req transaction, in order: kind 0 with
//   body_byte, kind 1 when the terminating empty trailer line is seen, kind 2
//   with error_code. An error holds the decoder until a restart.
// cfg: 16-bit write of max_line_bytes; write only while the decoder is idle.
// Throughput is one req transaction per cycle while the queue is not full: a
// classifier feeds a four-entry queue, and the parser pops one entry per cycle,
// unless rsp is stalled, into the result register that drives rsp valid.
// When rsp is stalled the result register holds, the parser stops popping and
// the queue absorbs up to four further transactions before req.ready drops.
// Reset clears the queue, the parser state and the result valid flag, and sets
// max_line_bytes to 16384; req.ready is high as soon as reset is released.
module http_chunked_body_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	hcd_req_if.sink     req,
	hcd_rsp_if.source   rsp,
	hcd_cfg_if.sink     cfg
);

	logic [hcd_pkg::LINE_W-1:0] max_line_q;
	logic                       full;
	logic                       empty;
	logic                       push;
	logic                       pop;
	hcd_pkg::item_t             push_item;
	hcd_pkg::item_t             pop_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q <= hcd_pkg::MAX_LINE_RESET;
		end else if (cfg.valid) begin
			max_line_q <= cfg.data;
		end
	end

	hcd_front u_front (
		.req  (req),
		.full (full),
		.push (push),
		.item (push_item)
	);

	hcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	hcd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.max_line (max_line_q),
		.empty    (empty),
		.item     (pop_item),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule
